// ===== sv/spms_pkg.sv =====
// Shared types and constants for the shared-pool multi-stack unit.
package spms_pkg;

  localparam int NUM_STACKS   = 8;
  localparam int POOL_ENTRIES = 64;

  localparam int SN_W      = 3;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = $clog2(POOL_ENTRIES);
  localparam int LINK_W    = $clog2(POOL_ENTRIES + 1);
  localparam int STK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // one past the last entry marks the end of a chain
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_ENTRIES);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic load;       // capture the input word
    logic issue;      // start the link / value memory access
    logic post_fail;  // write a failure result
    logic commit;     // update links, tops, free head and write the result
  } cmd_t;

  typedef struct packed {
    logic hit;        // the operation can proceed
    logic slot_free;  // output register can take a word this cycle
  } stat_t;

endpackage

// ===== sv/spms_ifs.sv =====
// Handshake interfaces for the operation and result channels.
interface spms_op_if;
  logic                          valid;
  logic                          ready;
  spms_pkg::action_e             action;
  logic [spms_pkg::SN_W-1:0]     stack_number;
  logic signed [spms_pkg::VAL_W-1:0] push_value;

  modport source (output valid, action, stack_number, push_value, input ready);
  modport sink   (input valid, action, stack_number, push_value, output ready);
endinterface

interface spms_res_if;
  logic                          valid;
  logic                          ready;
  spms_pkg::status_e             status;
  logic signed [spms_pkg::VAL_W-1:0] pop_value;

  modport source (output valid, status, pop_value, input ready);
  modport sink   (input valid, status, pop_value, output ready);
endinterface

// ===== sv/shared_pool_multi_stack_unit.sv =====
// Top level of the shared-pool multi-stack unit.
//  channel  | dir | word
//  op_i     | in  | action, stack_number, push_value
//  res_o    | out | status, pop_value
// An operation is looked up (stack top or free head) in the lookup state, which
// reads the link store into a register; the update then commits in the update state.
// A push to a full pool or a pop of an empty stack posts its failure from the lookup.
// The next word is taken in the cycle a result is written to the output register.
// A stalled result holds the unit in its last step until the register drains.
// Reset empties every stack and threads all entries onto the free list at once.
module shared_pool_multi_stack_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spms_op_if.sink    op_i,
  spms_res_if.source res_o
);

  spms_pkg::cmd_t  cmd;
  spms_pkg::stat_t stat;

  spms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (op_i.valid),
    .in_ready_o (op_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spms_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (op_i.action),
    .stack_number_i (op_i.stack_number),
    .push_value_i   (op_i.push_value),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .status_o       (res_o.status),
    .pop_value_o    (res_o.pop_value)
  );

endmodule

// ===== sv/spms_ctrl.sv =====
// Sequencing state machine for the shared-pool multi-stack unit.
module spms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  spms_pkg::stat_t stat_i,
  output spms_pkg::cmd_t  cmd_o
);

  spms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      spms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = spms_pkg::ST_LOOK;
        end
      end
      spms_pkg::ST_LOOK: begin
        if (stat_i.hit) begin
          cmd_o.issue = 1'b1;
          state_d     = spms_pkg::ST_UPD;
        end else if (stat_i.slot_free) begin
          cmd_o.post_fail = 1'b1;
          in_ready_o      = 1'b1;
          cmd_o.load      = in_valid_i;
          state_d         = in_valid_i ? spms_pkg::ST_LOOK : spms_pkg::ST_IDLE;
        end
      end
      spms_pkg::ST_UPD: begin
        if (stat_i.slot_free) begin
          cmd_o.commit = 1'b1;
          in_ready_o   = 1'b1;
          cmd_o.load   = in_valid_i;
          state_d      = in_valid_i ? spms_pkg::ST_LOOK : spms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/spms_dpath.sv =====
// Datapath: stack tops, free head, link and value stores, result register.
module spms_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spms_pkg::cmd_t                    cmd_i,
  output spms_pkg::stat_t                   stat_o,
  input  spms_pkg::action_e                 action_i,
  input  logic [spms_pkg::SN_W-1:0]         stack_number_i,
  input  logic signed [spms_pkg::VAL_W-1:0] push_value_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output spms_pkg::status_e                 status_o,
  output logic signed [spms_pkg::VAL_W-1:0] pop_value_o
);

  localparam int IDX_W  = spms_pkg::IDX_W;
  localparam int LINK_W = spms_pkg::LINK_W;
  localparam int VAL_W  = spms_pkg::VAL_W;

  // latched operation
  spms_pkg::action_e            act_q;
  logic [spms_pkg::SN_W-1:0]    sn_q;
  logic signed [VAL_W-1:0]      val_q;

  logic [LINK_W-1:0] tops_q [spms_pkg::NUM_STACKS];
  logic [LINK_W-1:0] free_head_q;

  logic [VAL_W-1:0]  val_mem  [spms_pkg::POOL_ENTRIES];
  logic [LINK_W-1:0] link_mem [spms_pkg::POOL_ENTRIES];
  logic [spms_pkg::POOL_ENTRIES-1:0] link_vld_q;

  logic [VAL_W-1:0]  val_rd_q;
  logic [LINK_W-1:0] link_rd_q;
  logic [IDX_W-1:0]  link_ra_q;
  logic              link_rd_vld_q;

  logic                     res_valid_q;
  spms_pkg::status_e        status_q;
  logic signed [VAL_W-1:0]  pop_value_q;

  logic [spms_pkg::STK_IDX_W-1:0] sidx;
  logic              sn_ok;
  logic [LINK_W-1:0] top;
  logic [LINK_W-1:0] link_rd;
  logic [IDX_W-1:0]  idx;
  logic              is_push;
  logic              link_we;
  logic [LINK_W-1:0] link_wd;

  assign is_push = (act_q == spms_pkg::ACT_PUSH);
  assign sidx    = spms_pkg::STK_IDX_W'(sn_q);
  assign sn_ok   = (32'(sn_q) < 32'(spms_pkg::NUM_STACKS));
  assign top     = tops_q[sidx];
  assign idx     = is_push ? free_head_q[IDX_W-1:0] : top[IDX_W-1:0];

  // an entry never written still carries its reset link, i+1
  assign link_rd = link_rd_vld_q ? link_rd_q
                                 : LINK_W'({1'b0, link_ra_q}) + LINK_W'(1);

  assign stat_o.hit = sn_ok && (is_push ? (free_head_q < spms_pkg::LINK_NULL)
                                        : (top < spms_pkg::LINK_NULL));
  assign stat_o.slot_free = !res_valid_q || res_ready_i;

  assign link_we = cmd_i.commit;
  assign link_wd = is_push ? top : free_head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      sn_q  <= stack_number_i;
      val_q <= push_value_i;
    end
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && is_push) begin
      val_mem[idx] <= val_q;
    end
    if (cmd_i.issue && !is_push) begin
      val_rd_q <= val_mem[idx];
    end
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[idx] <= link_wd;
    end
    if (cmd_i.issue) begin
      link_rd_q <= link_mem[idx];
      link_ra_q <= idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      link_rd_vld_q <= 1'b0;
    end else begin
      if (link_we) begin
        link_vld_q[idx] <= 1'b1;
      end
      if (cmd_i.issue) begin
        link_rd_vld_q <= link_vld_q[idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
        tops_q[i] <= spms_pkg::LINK_NULL;
      end
      free_head_q <= '0;
    end else if (cmd_i.commit) begin
      if (is_push) begin
        tops_q[sidx] <= LINK_W'({1'b0, idx});
        free_head_q  <= link_rd;
      end else begin
        tops_q[sidx] <= link_rd;
        free_head_q  <= LINK_W'({1'b0, idx});
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.post_fail) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post_fail) begin
      status_q    <= is_push ? spms_pkg::STATUS_FULL : spms_pkg::STATUS_EMPTY;
      pop_value_q <= '0;
    end else if (cmd_i.commit) begin
      status_q    <= spms_pkg::STATUS_OK;
      pop_value_q <= is_push ? '0 : val_rd_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign pop_value_o = pop_value_q;

`ifndef SYNTHESIS
  a_no_double_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && cmd_i.post_fail))
    else $error("commit and failure result in the same cycle");

  a_commit_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> stat_o.hit)
    else $error("commit without a valid target entry");

  a_issue_then_no_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> !cmd_i.post_fail)
    else $error("failure posted after a memory access was issued");

  a_result_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.post_fail) |=> res_valid_q)
    else $error("result word lost");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= spms_pkg::LINK_NULL)
    else $error("free head beyond the null mark");
`endif

endmodule

// ===== sim/shared_pool_multi_stack_unit_tb.sv =====
// Testbench for the shared-pool multi-stack unit: directed and random push/pop traffic against a predictor.
module shared_pool_multi_stack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_GOAL   = 900;

  typedef struct {
    spms_pkg::action_e                      action;
    logic [spms_pkg::SN_W-1:0]              sn;
    logic signed [spms_pkg::VAL_W-1:0]      value;
  } op_word_t;

  typedef struct {
    spms_pkg::status_e                      status;
    logic signed [spms_pkg::VAL_W-1:0]      value;
  } res_word_t;

  // Mirror of the pool, the free list and the stack tops; one awaited result per op.
  class stack_result_board;
    logic signed [spms_pkg::VAL_W-1:0] entry_values [spms_pkg::POOL_ENTRIES];
    logic [spms_pkg::LINK_W-1:0]       entry_links [spms_pkg::POOL_ENTRIES];
    logic [spms_pkg::LINK_W-1:0]       stack_tops [spms_pkg::NUM_STACKS];
    logic [spms_pkg::LINK_W-1:0]       free_head;
    res_word_t                         awaited[$];
    int errors, checked, noted;
    int n_push_ok, n_full, n_pop_ok, n_empty;

    function new();
      for (int i = 0; i < spms_pkg::POOL_ENTRIES; i++) begin
        entry_values[i] = '0;
        entry_links[i]  = spms_pkg::LINK_W'(i + 1);
      end
      entry_links[spms_pkg::POOL_ENTRIES-1] = spms_pkg::LINK_NULL;
      for (int s = 0; s < spms_pkg::NUM_STACKS; s++) stack_tops[s] = spms_pkg::LINK_NULL;
      free_head = '0;
    endfunction

    function res_word_t apply_stack_op(op_word_t w);
      res_word_t                   r;
      logic [spms_pkg::LINK_W-1:0] slot;
      r.status = spms_pkg::STATUS_OK;
      r.value  = '0;
      if (w.action == spms_pkg::ACT_PUSH) begin
        slot = free_head;
        if (int'(w.sn) >= spms_pkg::NUM_STACKS || slot >= spms_pkg::POOL_ENTRIES) begin
          r.status = spms_pkg::STATUS_FULL;
          n_full++;
        end else begin
          free_head          = entry_links[slot];
          entry_values[slot] = w.value;
          entry_links[slot]  = stack_tops[w.sn];
          stack_tops[w.sn]   = slot;
          n_push_ok++;
        end
      end else begin
        slot = (int'(w.sn) < spms_pkg::NUM_STACKS) ? stack_tops[w.sn] : spms_pkg::LINK_NULL;
        if (slot >= spms_pkg::POOL_ENTRIES) begin
          r.status = spms_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          stack_tops[w.sn]  = entry_links[slot];
          entry_links[slot] = free_head;
          free_head         = slot;
          r.value           = entry_values[slot];
          n_pop_ok++;
        end
      end
      return r;
    endfunction

    function void note_op(op_word_t w);
      noted++;
      awaited.push_back(apply_stack_op(w));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 20) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(spms_pkg::status_e status, logic signed [spms_pkg::VAL_W-1:0] value);
      res_word_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing awaited", checked));
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("word %0d status %0d, want %0d",
                                    checked, status, want.status));
        if (value !== want.value)
          report_mismatch($sformatf("word %0d pop_value %0h, want %0h",
                                    checked, value, want.value));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  spms_op_if  op_bus ();
  spms_res_if res_bus ();

  stack_result_board sb = new();

  shared_pool_multi_stack_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_bus),
    .res_o  (res_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // accepted words, sampled before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni && op_bus.valid && op_bus.ready) begin
      sb.note_op('{op_bus.action, op_bus.stack_number, op_bus.push_value});
    end
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      sb.check_result(res_bus.status, res_bus.pop_value);
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.awaited.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: rotating stall patterns, plus one long hold once traffic is flowing
  initial begin
    int  cyc;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && sb.checked >= 300) begin
        held = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      case ((cyc / 97) % 4)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= ($urandom_range(0, 1) == 1);
        2:       res_bus.ready <= (cyc % 4 != 0);
        default: res_bus.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic offer_op(input op_word_t w);
    op_bus.valid        <= 1'b1;
    op_bus.action       <= w.action;
    op_bus.stack_number <= w.sn;
    op_bus.push_value   <= w.value;
    do @(posedge clk_i); while (op_bus.ready !== 1'b1);
  endtask

  // hold off until every awaited result is back; step past the current edge first so the last word is noted
  task automatic drain_results();
    op_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() > 0) @(posedge clk_i);
  endtask

  function automatic op_word_t random_op(int push_pct, bit focus);
    op_word_t w;
    w.action = ($urandom_range(1, 100) <= push_pct) ? spms_pkg::ACT_PUSH : spms_pkg::ACT_POP;
    w.sn     = focus ? spms_pkg::SN_W'($urandom_range(0, 1))
                     : spms_pkg::SN_W'($urandom_range(0, spms_pkg::NUM_STACKS - 1));
    case ($urandom_range(0, 9))
      0:       w.value = 32'h7fff_ffff;
      1:       w.value = 32'h8000_0000;
      2:       w.value = '0;
      3:       w.value = '1;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  task automatic run_segment(int count, int push_pct, bit focus);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) offer_op(random_op(push_pct, focus));
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        op_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int push_mix[7] = '{80, 20, 50, 90, 10, 60, 35};
    int seg;
    int len;
    rst_ni = 1'b0;
    op_bus.valid        <= 1'b0;
    op_bus.action       <= spms_pkg::ACT_PUSH;
    op_bus.stack_number <= '0;
    op_bus.push_value   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, value extremes on the outer stacks, LIFO order
    offer_op('{spms_pkg::ACT_POP,  3'd0, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd7, 32'hffff_ffff});
    offer_op('{spms_pkg::ACT_PUSH, 3'd0, 32'h7fff_ffff});
    offer_op('{spms_pkg::ACT_PUSH, 3'd0, 32'h8000_0000});
    offer_op('{spms_pkg::ACT_PUSH, 3'd7, 32'hffff_ffff});
    offer_op('{spms_pkg::ACT_PUSH, 3'd7, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_PUSH, 3'd5, 32'h5555_5555});
    offer_op('{spms_pkg::ACT_PUSH, 3'd5, 32'haaaa_aaaa});
    offer_op('{spms_pkg::ACT_POP,  3'd0, 32'h1234_5678});
    offer_op('{spms_pkg::ACT_POP,  3'd0, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd0, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd7, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd7, 32'hdead_beef});
    offer_op('{spms_pkg::ACT_POP,  3'd5, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd5, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd5, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_PUSH, 3'd2, 32'h0000_0001});
    offer_op('{spms_pkg::ACT_PUSH, 3'd6, 32'hffff_fffe});
    offer_op('{spms_pkg::ACT_POP,  3'd6, 32'h0000_0000});
    offer_op('{spms_pkg::ACT_POP,  3'd2, 32'h0000_0000});
    drain_results();

    // exhaust the pool, push into a full pool, then unwind
    run_segment(72, 100, 1'b0);
    run_segment(90, 0, 1'b0);
    drain_results();

    seg = 0;
    while (sb.noted < ITEM_GOAL) begin
      len = $urandom_range(40, 120);
      run_segment(len, push_mix[seg % 7], seg % 3 == 1);
      if (seg == 3) drain_results();
      seg++;
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    if (sb.awaited.size() > 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
    $display("covered %0d words: %0d pushes stored, %0d refused on a full pool",
             sb.noted, sb.n_push_ok, sb.n_full);
    $display("%0d pops returned a word, %0d hit an empty stack; %0d results checked",
             sb.n_pop_ok, sb.n_empty, sb.checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== shared_pool_multi_stack_unit.f =====
sv/spms_pkg.sv
sv/spms_ifs.sv
sv/spms_ctrl.sv
sv/spms_dpath.sv
sv/shared_pool_multi_stack_unit.sv
sim/shared_pool_multi_stack_unit_tb.sv
